// File: rtl/sgd_pkg.sv
// Shared types and constants for the signed gadget decomposition block.
package sgd_pkg;

  localparam int WORD_W      = 64;
  localparam int NUM_WORDS   = 4;
  localparam int NUM_W       = WORD_W * NUM_WORDS;
  localparam int MOD_W       = 61;
  localparam int LANES       = 4;
  localparam int DIGIT_CNT_W = 7;
  localparam int DIGIT_IDX_W = 6;
  localparam int MCOUNT_W    = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CNT_W       = 8;

  localparam int NUM_MODULI_DEF = 4;
  localparam int MAX_DIGITS_DEF = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGITS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MCOUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_3 = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_DIV,
    ST_BAL,
    ST_MOD,
    ST_EMIT
  } sgd_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                   load;
    logic                   align;
    logic                   div_step;
    logic                   balance;
    logic                   mod_step;
    logic                   emit;
    logic                   last;
    logic [DIGIT_IDX_W-1:0] digit_index;
  } sgd_cmd_t;

endpackage

// File: rtl/sgd_ctrl.sv
// Sequencing state machine for the decomposition: alignment, division, balancing, reduction, output.
module sgd_ctrl import sgd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [DIGIT_CNT_W-1:0] digits,
  input  logic [MCOUNT_W-1:0]    mcount,
  output logic                   busy,
  output sgd_cmd_t               cmd
);

  sgd_state_t             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [DIGIT_IDX_W-1:0] idx_r, idx_nxt;
  logic [1:0]             mtop;
  logic                   div_done, mod_done, last;

  // Division runs over the active words only, one bit per cycle.
  assign mtop     = 2'(mcount - 3'd1);
  assign div_done = (cnt_r == {mtop, 6'h3f});
  assign mod_done = (cnt_r[5:0] == 6'h3f);
  assign last     = ((7'({1'b0, idx_r}) + 7'd1) == digits);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_ALIGN;
          idx_nxt   = '0;
        end
      end
      ST_ALIGN: begin
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (div_done) begin
          state_nxt = ST_BAL;
        end
      end
      ST_BAL: begin
        state_nxt = ST_MOD;
        cnt_nxt   = '0;
      end
      ST_MOD: begin
        cnt_nxt = cnt_r + 1'b1;
        if (mod_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        idx_nxt   = idx_r + 1'b1;
        state_nxt = last ? ST_IDLE : ST_ALIGN;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd             = '0;
    cmd.digit_index = idx_r;
    cmd.last        = last;
    busy            = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE:  cmd.load     = start;
      ST_ALIGN: cmd.align    = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_BAL:   cmd.balance  = 1'b1;
      ST_MOD:   cmd.mod_step = 1'b1;
      ST_EMIT:  cmd.emit     = 1'b1;
      default:  cmd.load     = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // At most one datapath operation is issued per cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.align, cmd.div_step, cmd.balance, cmd.mod_step, cmd.emit}))
    else $error("more than one datapath command");

  // An accepted transaction makes the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) cmd.load |=> busy)
    else $error("load did not start a transaction");

  // The final digit returns the block to idle.
  assert property (@(posedge clk) disable iff (!rst_n) (cmd.emit && cmd.last) |=> !busy)
    else $error("block still busy after final digit");

endmodule

// File: rtl/sgd_datapath.sv
// Datapath: bit-serial long division, digit balancing and per-modulus bit-serial reduction.
module sgd_datapath import sgd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sgd_cmd_t                    cmd,
  input  logic [NUM_WORDS-1:0][WORD_W-1:0] words,
  input  logic [WORD_W-1:0]           zbase,
  input  logic [LANES-1:0][MOD_W-1:0] moduli,
  input  logic [MCOUNT_W-1:0]         mcount,
  output logic [LANES-1:0][MOD_W-1:0] residue,
  output logic [DIGIT_IDX_W-1:0]      digit_index,
  output logic                        last_digit,
  output logic                        carry_lost,
  output logic                        strobe
);

  logic [NUM_W-1:0]              num_r;
  logic [WORD_W-1:0]             rem_r, mag_r;
  logic                          neg_r, carry_r;
  logic [LANES-1:0][MOD_W-1:0]   acc_r;
  logic [LANES-1:0][MOD_W-1:0]   res_r;
  logic [DIGIT_IDX_W-1:0]        idx_r;
  logic                          last_r, lost_r, strobe_r;

  logic [NUM_W-1:0]              num_load, num_aligned;
  logic [WORD_W-1:0]             rem_sh, rem_sub, half, mag_nxt;
  logic                          ge;
  logic [WORD_W-1:0]             v;
  logic                          neg_nxt;
  logic [LANES-1:0][MOD_W:0]     acc_sh;
  logic [LANES-1:0][MOD_W-1:0]   acc_nxt, res_nxt;
  logic [LANES-1:0]              lane_en;

  // Words beyond the modulus count are taken as zero.
  always_comb begin
    for (int j = 0; j < NUM_WORDS; j++) begin
      num_load[j*WORD_W +: WORD_W] = (j < int'(mcount)) ? words[j] : '0;
    end
  end

  // Left-justify the active words so that division starts at their top bit.
  always_comb begin
    unique case (mcount)
      3'd1:    num_aligned = num_r << (3 * WORD_W);
      3'd2:    num_aligned = num_r << (2 * WORD_W);
      3'd3:    num_aligned = num_r << WORD_W;
      default: num_aligned = num_r;
    endcase
  end

  // One restoring division step; a set top bit forces subtraction.
  assign rem_sh  = {rem_r[WORD_W-2:0], num_r[NUM_W-1]};
  assign ge      = rem_r[WORD_W-1] | (rem_sh >= zbase);
  assign rem_sub = rem_sh - zbase;

  // Balance the remainder plus incoming carry; the remainder is below the base,
  // so the sum always fits in one word.
  assign half    = zbase >> 1;
  assign v       = rem_r + {{(WORD_W-1){1'b0}}, carry_r};
  assign neg_nxt = (v > half);
  assign mag_nxt = neg_nxt ? (zbase - v) : v;

  // Reduction lanes, one per modulus.
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      lane_en[j] = (j < int'(mcount)) && (moduli[j] >= MOD_W'(2));
      acc_sh[j]  = {acc_r[j], mag_r[WORD_W-1]};
      acc_nxt[j] = (acc_sh[j] >= {1'b0, moduli[j]}) ?
                   MOD_W'(acc_sh[j] - {1'b0, moduli[j]}) : acc_sh[j][MOD_W-1:0];
      if (!lane_en[j]) begin
        res_nxt[j] = '0;
      end else if (neg_r && (acc_r[j] != '0)) begin
        res_nxt[j] = moduli[j] - acc_r[j];
      end else begin
        res_nxt[j] = acc_r[j];
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r <= num_load;
    end else if (cmd.align) begin
      num_r <= num_aligned;
    end else if (cmd.div_step) begin
      num_r <= {num_r[NUM_W-2:0], ge};
    end
    if (cmd.align) begin
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? rem_sub : rem_sh;
    end
    if (cmd.balance) begin
      mag_r <= mag_nxt;
      neg_r <= neg_nxt;
      acc_r <= '0;
    end else if (cmd.mod_step) begin
      mag_r <= {mag_r[WORD_W-2:0], 1'b0};
      acc_r <= acc_nxt;
    end
    if (cmd.emit) begin
      res_r  <= res_nxt;
      idx_r  <= cmd.digit_index;
      last_r <= cmd.last;
      lost_r <= cmd.last & neg_r;
    end
  end

  // Carry and result strobe are control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r  <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        carry_r <= 1'b0;
      end else if (cmd.balance) begin
        carry_r <= neg_nxt;
      end
      strobe_r <= cmd.emit;
    end
  end

  assign residue     = res_r;
  assign digit_index = idx_r;
  assign last_digit  = last_r;
  assign carry_lost  = lost_r;
  assign strobe      = strobe_r;

  // A lost carry is only ever reported on the final digit.
  assert property (@(posedge clk) disable iff (!rst_n) (strobe && carry_lost) |-> last_digit)
    else $error("carry flagged on a digit that is not the last");

  // Results are separated by the reduction pass, so strobes never run together.
  assert property (@(posedge clk) disable iff (!rst_n) strobe |=> !strobe)
    else $error("back-to-back result strobes");

endmodule

// File: rtl/signed_gadget_decompose_rns_core.sv
// Top level of the signed base-z gadget decomposition into RNS residues.
// One number of up to four 64-bit words is taken when start is high and busy low.
// Each digit passes through an alignment step, a bit-serial long division over the active
// words, a balancing step, a bit-serial reduction run in parallel for all moduli, and
// an output step.
// Each result appears for a single cycle with out_strobe high and cannot be held off,
// so the receiver must take it then. Configuration is taken only while busy and start
// are both low, so a transaction never sees a register change under it.
module signed_gadget_decompose_rns_core import sgd_pkg::*; #(
  parameter int NUM_MODULI = NUM_MODULI_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [WORD_W-1:0]    in_word_0,
  input  logic [WORD_W-1:0]    in_word_1,
  input  logic [WORD_W-1:0]    in_word_2,
  input  logic [WORD_W-1:0]    in_word_3,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  output logic                 out_strobe,
  output logic [MOD_W-1:0]     out_residue_0,
  output logic [MOD_W-1:0]     out_residue_1,
  output logic [MOD_W-1:0]     out_residue_2,
  output logic [MOD_W-1:0]     out_residue_3,
  output logic [DIGIT_IDX_W-1:0] out_digit_index,
  output logic                 out_last_digit,
  output logic                 out_carry_lost
);

  localparam int MLIM = (NUM_MODULI < LANES) ? NUM_MODULI : LANES;

  logic [WORD_W-1:0]           base_r;
  logic [DIGIT_CNT_W-1:0]      digits_r;
  logic [MCOUNT_W-1:0]         mcount_r;
  logic [LANES-1:0][MOD_W-1:0] moduli_r;

  logic [WORD_W-1:0]           zbase;
  logic [DIGIT_CNT_W-1:0]      digits_eff;
  logic [MCOUNT_W-1:0]         mcount_eff;
  logic [LANES-1:0][MOD_W-1:0] residue;
  sgd_cmd_t                    cmd;

  assign cfg_ready = !busy && !start;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= WORD_W'(2);
      digits_r <= DIGIT_CNT_W'(1);
      mcount_r <= MCOUNT_W'(1);
      moduli_r <= {LANES{MOD_W'(2)}};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BASE:      base_r      <= cfg_data;
        CFG_DIGITS:    digits_r    <= cfg_data[DIGIT_CNT_W-1:0];
        CFG_MCOUNT:    mcount_r    <= cfg_data[MCOUNT_W-1:0];
        CFG_MODULUS_0: moduli_r[0] <= cfg_data[MOD_W-1:0];
        CFG_MODULUS_1: moduli_r[1] <= cfg_data[MOD_W-1:0];
        CFG_MODULUS_2: moduli_r[2] <= cfg_data[MOD_W-1:0];
        CFG_MODULUS_3: moduli_r[3] <= cfg_data[MOD_W-1:0];
        default:       base_r      <= base_r;
      endcase
    end
  end

  // Out-of-range settings are clamped to their nearest legal value.
  assign zbase = (base_r < WORD_W'(2)) ? WORD_W'(2) : base_r;

  always_comb begin
    if (digits_r == '0) begin
      digits_eff = DIGIT_CNT_W'(1);
    end else if (digits_r > DIGIT_CNT_W'(MAX_DIGITS)) begin
      digits_eff = DIGIT_CNT_W'(MAX_DIGITS);
    end else begin
      digits_eff = digits_r;
    end
    if (mcount_r == '0) begin
      mcount_eff = MCOUNT_W'(1);
    end else if (mcount_r > MCOUNT_W'(MLIM)) begin
      mcount_eff = MCOUNT_W'(MLIM);
    end else begin
      mcount_eff = mcount_r;
    end
  end

  sgd_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .digits (digits_eff),
    .mcount (mcount_eff),
    .busy   (busy),
    .cmd    (cmd)
  );

  sgd_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .words       ({in_word_3, in_word_2, in_word_1, in_word_0}),
    .zbase       (zbase),
    .moduli      (moduli_r),
    .mcount      (mcount_eff),
    .residue     (residue),
    .digit_index (out_digit_index),
    .last_digit  (out_last_digit),
    .carry_lost  (out_carry_lost),
    .strobe      (out_strobe)
  );

  assign out_residue_0 = residue[0];
  assign out_residue_1 = residue[1];
  assign out_residue_2 = residue[2];
  assign out_residue_3 = residue[3];

endmodule

// File: tb/tb.sv
// Self-checking testbench for the signed gadget decomposition core.
module tb;
  import sgd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 40000;

  // One balanced digit as the core presents it.
  typedef struct packed {
    logic [MOD_W-1:0]       res0;
    logic [MOD_W-1:0]       res1;
    logic [MOD_W-1:0]       res2;
    logic [MOD_W-1:0]       res3;
    logic [DIGIT_IDX_W-1:0] idx;
    logic                   last;
    logic                   lost;
  } digit_t;

  // Predicts the digit stream of each number and checks the core against it.
  class digit_scoreboard;
    bit [WORD_W-1:0]      base_reg;
    bit [DIGIT_CNT_W-1:0] digits_reg;
    bit [MCOUNT_W-1:0]    mcount_reg;
    bit [MOD_W-1:0]       modulus_reg[LANES];
    digit_t               expected_digits[$];
    int                   errors;

    function new();
      base_reg   = 2;
      digits_reg = 1;
      mcount_reg = 1;
      foreach (modulus_reg[j]) modulus_reg[j] = 2;
      errors = 0;
    endfunction

    // A configuration write seen on the register channel.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      case (idx)
        CFG_BASE:      base_reg = data;
        CFG_DIGITS:    digits_reg = data[DIGIT_CNT_W-1:0];
        CFG_MCOUNT:    mcount_reg = data[MCOUNT_W-1:0];
        CFG_MODULUS_0: modulus_reg[0] = data[MOD_W-1:0];
        CFG_MODULUS_1: modulus_reg[1] = data[MOD_W-1:0];
        CFG_MODULUS_2: modulus_reg[2] = data[MOD_W-1:0];
        CFG_MODULUS_3: modulus_reg[3] = data[MOD_W-1:0];
        default: ;
      endcase
    endfunction

    // An accepted number: peel off its balanced digits and queue them.
    function void note_number(bit [WORD_W-1:0] w0, bit [WORD_W-1:0] w1,
                              bit [WORD_W-1:0] w2, bit [WORD_W-1:0] w3);
      bit [NUM_W-1:0]  num;
      bit [WORD_W-1:0] z, half, r, v, mag, t, m;
      bit [WORD_W-1:0] words[NUM_WORDS];
      bit [MOD_W-1:0]  res[LANES];
      bit              neg, carry;
      int              nd, nm;
      digit_t          d;
      z    = (base_reg < 2) ? 64'd2 : base_reg;
      half = z >> 1;
      nd   = (digits_reg == 0) ? 1 : int'(digits_reg);
      if (nd > MAX_DIGITS_DEF) nd = MAX_DIGITS_DEF;
      nm   = (mcount_reg == 0) ? 1 : int'(mcount_reg);
      if (nm > LANES) nm = LANES;
      if (nm > NUM_MODULI_DEF) nm = NUM_MODULI_DEF;
      words[0] = w0; words[1] = w1; words[2] = w2; words[3] = w3;
      num = '0;
      for (int j = 0; j < nm; j++) num[j*WORD_W +: WORD_W] = words[j];
      carry = 0;
      for (int i = 0; i < nd; i++) begin
        r   = WORD_W'(num % NUM_W'(z));
        num = num / NUM_W'(z);
        v   = r + WORD_W'(carry);
        neg = v > half;
        mag = neg ? z - v : v;
        for (int j = 0; j < LANES; j++) begin
          res[j] = '0;
          if (j < nm && modulus_reg[j] >= 2) begin
            m = WORD_W'(modulus_reg[j]);
            t = mag % m;
            res[j] = MOD_W'((neg && t != 0) ? m - t : t);
          end
        end
        carry  = neg;
        d.res0 = res[0];
        d.res1 = res[1];
        d.res2 = res[2];
        d.res3 = res[3];
        d.idx  = DIGIT_IDX_W'(i);
        d.last = (i + 1 == nd);
        d.lost = (i + 1 == nd) ? carry : 1'b0;
        expected_digits.push_back(d);
      end
    endfunction

    // A digit strobed out by the core, compared with the oldest prediction.
    function void check_digit(digit_t got);
      digit_t exp;
      if (expected_digits.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected digit: %p", got);
        return;
      end
      exp = expected_digits.pop_front();
      if (got.res0 !== exp.res0 || got.res1 !== exp.res1 || got.res2 !== exp.res2 ||
          got.res3 !== exp.res3 || got.idx !== exp.idx || got.last !== exp.last ||
          got.lost !== exp.lost) begin
        errors++;
        if (errors <= 10) begin
          $display("digit mismatch: expected %p", exp);
          $display("                actual   %p", got);
        end
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [WORD_W-1:0]      in_word_0, in_word_1, in_word_2, in_word_3;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [WORD_W-1:0]      cfg_data;
  logic                   out_strobe;
  logic [MOD_W-1:0]       out_residue_0, out_residue_1, out_residue_2, out_residue_3;
  logic [DIGIT_IDX_W-1:0] out_digit_index;
  logic                   out_last_digit;
  logic                   out_carry_lost;

  digit_scoreboard sb = new();
  int              quiet_cycles = 0;
  int              idle_pct = 0;

  signed_gadget_decompose_rns_core u_top (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Observe every transaction at the rising edge and keep the watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note_number(in_word_0, in_word_1, in_word_2, in_word_3);
      if (out_strobe)
        sb.check_digit({out_residue_0, out_residue_1, out_residue_2, out_residue_3,
                        out_digit_index, out_last_digit, out_carry_lost});
      if ((cfg_valid && cfg_ready) || (start && !busy) || out_strobe) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("signed_gadget_decompose_rns_core test failed");
        $finish;
      end
    end
  end

  // Write one configuration register.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Let every predicted digit arrive and the core fall idle.
  task automatic drain();
    while (sb.expected_digits.size() != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Reconfigure the whole register set once the core is idle.
  task automatic configure(logic [WORD_W-1:0] b, logic [WORD_W-1:0] dc,
                           logic [WORD_W-1:0] mc, logic [WORD_W-1:0] m0,
                           logic [WORD_W-1:0] m1, logic [WORD_W-1:0] m2,
                           logic [WORD_W-1:0] m3);
    drain();
    write_cfg(CFG_BASE, b);
    write_cfg(CFG_DIGITS, dc);
    write_cfg(CFG_MCOUNT, mc);
    write_cfg(CFG_MODULUS_0, m0);
    write_cfg(CFG_MODULUS_1, m1);
    write_cfg(CFG_MODULUS_2, m2);
    write_cfg(CFG_MODULUS_3, m3);
  endtask

  // Offer one number after a random idle stretch and hold it until taken.
  task automatic send_number(logic [WORD_W-1:0] w0, logic [WORD_W-1:0] w1,
                             logic [WORD_W-1:0] w2, logic [WORD_W-1:0] w3);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    start     = 1'b1;
    in_word_0 = w0;
    in_word_1 = w1;
    in_word_2 = w2;
    in_word_3 = w3;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return WORD_W'($urandom_range(15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rand_modulus();
    case ($urandom_range(7))
      0: return WORD_W'($urandom_range(3));
      1: return {3'b000, {61{1'b1}}};
      2: return WORD_W'($urandom_range(100, 2));
      default: return {3'b000, 61'({$urandom, $urandom})} | 64'd2;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rand_base();
    case ($urandom_range(5))
      0: return WORD_W'($urandom_range(17));
      1: return 64'd1 << $urandom_range(63, 1);
      2: return WORD_W'($urandom_range(1000, 2));
      default: return {1'b0, 63'({$urandom, $urandom})} | 64'd2;
    endcase
  endfunction

  task automatic send_random(int n);
    repeat (n) send_number(rand_word(), rand_word(), rand_word(), rand_word());
  endtask

  // Main sequence: directed corners, then randomised phases.
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_word_0 = '0; in_word_1 = '0; in_word_2 = '0; in_word_3 = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_BASE;
    cfg_data  = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset settings first, then out-of-range base, digit and modulus counts.
    send_number(64'd5, '1, '1, '1);
    configure(64'd0, 64'd0, 64'd0, 64'd0, 64'd1, 64'd2, 64'd3);
    send_number('0, '0, '0, '0);
    send_number('1, '1, '1, '1);
    send_number(64'd1, 64'd0, 64'd0, 64'd0);
    send_number(64'h8000_0000_0000_0000, '1, '0, '1);

    // Base four on all-ones words gives digits equal to the base and a lost top carry.
    configure(64'd4, 64'd127, 64'd7, {3'b000, {61{1'b1}}}, 64'd1, 64'd0, 64'd5);
    send_number('1, '1, '1, '1);
    send_number('0, '0, '0, '0);
    send_random(2);

    // Base of 2^63 with two words in use.
    configure(64'h8000_0000_0000_0000, 64'd5, 64'd2, {3'b000, {61{1'b1}}}, 64'd3,
              {3'b000, {60{1'b1}}, 1'b0}, 64'd7);
    send_number('1, '1, '1, '1);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, 64'h4000_0000_0000_0000, '0, '0);
    send_random(3);

    // Odd base, three words, upper modulus bits set on the write.
    configure(64'd3, 64'd8, 64'd3, '1, 64'd2, 64'd9, 64'd1 << 60);
    send_number('1, '1, '1, '1);
    send_number(64'd2, 64'd0, '1, 64'd0);
    send_random(4);

    // Random phases cycling through the sender idle rates.
    for (int p = 0; p < 8; p++) begin
      configure(rand_base(), ($urandom_range(9) == 0) ? 64'($urandom_range(127))
                                                       : 64'($urandom_range(8, 1)),
                64'($urandom_range(7)), rand_modulus(), rand_modulus(),
                rand_modulus(), rand_modulus());
      case (p % 4)
        0: idle_pct = 0;
        1: idle_pct = 69;
        2: idle_pct = 0;
        default: idle_pct = 12;
      endcase
      send_random(11);
    end

    drain();
    repeat (200) @(negedge clk);
    if (sb.errors == 0 && sb.expected_digits.size() == 0)
      $display("signed_gadget_decompose_rns_core test passed");
    else
      $display("signed_gadget_decompose_rns_core test failed");
    $finish;
  end

endmodule
